FILE: rtl/core/mlq_pkg.sv
package mlq_pkg;

    localparam int NUM_PRIO_DEF    = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ID_W   = 8;
    localparam int PRIO_W = 3;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_GET = 1'b1;

endpackage

FILE: rtl/core/mlq_ram.sv
module mlq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/mlq_slot_budget_scheduler.sv
// Multilevel ready-queue scheduler with a slot budget per priority level.
// Command channel: raise start with op, proc_id and priority_req; the command
// transfers at a rising edge where start is high and busy is low.
// op add appends proc_id to the FIFO of priority_req; a full FIFO or a level
// of NUM_PRIO or above sets dropped. op get scans levels circularly from the
// current one and dequeues from the first non-empty level with budget left
// (NUM_PRIO minus level), clearing the counts of exhausted levels on the way.
// Result channel: done is high for exactly one cycle with granted, grant_id,
// grant_priority, dropped and all_empty; the receiver cannot stall it.
// The command is registered at the transfer edge and executed in the EXEC
// state; its result is on the ports in the RESP state that follows. busy is
// high in the EXEC state only, so a command may transfer in the result cycle;
// the block cannot take a new command while it executes one, as busy covers
// the registered read of the queue memory.
// Reset (rst_n low, asynchronous) empties every queue, clears all slot
// counts and the current level; the queue memory itself is not cleared and
// needs no clearing pass.
module mlq_slot_budget_scheduler #(
    parameter int NUM_PRIO    = mlq_pkg::NUM_PRIO_DEF,
    parameter int QUEUE_DEPTH = mlq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      op,
    input  logic [mlq_pkg::ID_W-1:0]   proc_id,
    input  logic [mlq_pkg::PRIO_W-1:0] priority_req,
    output logic                      done,
    output logic                      granted,
    output logic [mlq_pkg::ID_W-1:0]   grant_id,
    output logic [mlq_pkg::PRIO_W-1:0] grant_priority,
    output logic                      dropped,
    output logic                      all_empty
);

    localparam int LW    = $clog2(NUM_PRIO);
    localparam int XW    = ((LW > mlq_pkg::PRIO_W) ? LW : mlq_pkg::PRIO_W) + 1;
    localparam int HW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int UW    = $clog2(NUM_PRIO + 1);
    localparam int DEPTH = NUM_PRIO * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg, state_next;

    logic                       op_reg;
    logic [mlq_pkg::ID_W-1:0]   id_reg;
    logic [mlq_pkg::PRIO_W-1:0] prio_reg;

    logic [HW-1:0] head_reg  [NUM_PRIO];
    logic [HW-1:0] head_next [NUM_PRIO];
    logic [CW-1:0] count_reg  [NUM_PRIO];
    logic [CW-1:0] count_next [NUM_PRIO];
    logic [UW-1:0] used_reg  [NUM_PRIO];
    logic [UW-1:0] used_next [NUM_PRIO];
    logic [LW-1:0] cur_reg, cur_next;

    logic                       granted_reg, granted_next;
    logic [mlq_pkg::PRIO_W-1:0] gprio_reg, gprio_next;
    logic                       dropped_reg, dropped_next;
    logic                       empty_reg, empty_next;

    logic accept;
    logic exec;

    logic [NUM_PRIO-1:0] ne_vec;
    logic [NUM_PRIO-1:0] ok_vec;
    logic [NUM_PRIO-1:0] hi_mask;
    logic [NUM_PRIO-1:0] sel_vec;
    logic [NUM_PRIO-1:0] sel_oh;
    logic [NUM_PRIO-1:0] clr_vec;
    logic [NUM_PRIO-1:0] last_vec;
    logic [NUM_PRIO-1:0] last_rev;
    logic [NUM_PRIO-1:0] last_oh;
    logic                any_ok;
    logic                any_ne;
    logic [LW-1:0]       srv_lvl;
    logic [LW-1:0]       last_ridx;
    logic [LW-1:0]       wrap_lvl;

    logic [XW-1:0] lvl_x;
    logic          lvl_ok;
    logic [LW-1:0] add_lvl;
    logic          add_drop;
    logic [CW:0]   tail_sum;
    logic [HW-1:0] tail_pos;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [mlq_pkg::ID_W-1:0] ram_rdata;

    assign accept = start && !busy;
    assign exec   = (state_reg == S_EXEC);
    assign busy   = exec;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_RESP;
            S_RESP:  state_next = start ? S_EXEC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            id_reg   <= proc_id;
            prio_reg <= priority_req;
        end
    end

    // Level flags and circular scan
    genvar gp;
    generate
        for (gp = 0; gp < NUM_PRIO; gp++)
        begin : g_lvl
            assign ne_vec[gp]  = (count_reg[gp] != '0);
            assign ok_vec[gp]  = ne_vec[gp] && (used_reg[gp] < UW'(NUM_PRIO - gp));
            assign hi_mask[gp] = (cur_reg <= LW'(gp));
            assign clr_vec[gp] = ne_vec[gp] &&
                ((srv_lvl >= cur_reg) ? (hi_mask[gp] && (LW'(gp) < srv_lvl))
                                      : (hi_mask[gp] || (LW'(gp) < srv_lvl)));
            assign last_rev[gp] = last_vec[NUM_PRIO - 1 - gp];
        end
    endgenerate

    assign any_ok  = |ok_vec;
    assign any_ne  = |ne_vec;
    assign sel_vec = (|(ok_vec & hi_mask)) ? (ok_vec & hi_mask) : ok_vec;
    assign sel_oh  = sel_vec & (~sel_vec + 1'b1);

    // last non-empty level in scan order: the next scan starts after it
    assign last_vec = (|(ne_vec & ~hi_mask)) ? (ne_vec & ~hi_mask) : (ne_vec & hi_mask);
    assign last_oh  = last_rev & (~last_rev + 1'b1);

    always_comb
    begin
        srv_lvl   = '0;
        last_ridx = '0;
        for (int p = 0; p < NUM_PRIO; p++)
        begin
            if (sel_oh[p])
            begin
                srv_lvl = srv_lvl | LW'(p);
            end
            if (last_oh[p])
            begin
                last_ridx = last_ridx | LW'(p);
            end
        end
    end

    assign wrap_lvl = (last_ridx == '0) ? '0 : LW'(NUM_PRIO) - last_ridx;

    // Add path
    assign lvl_x    = XW'(prio_reg);
    assign lvl_ok   = (lvl_x < XW'(NUM_PRIO));
    assign add_lvl  = lvl_ok ? lvl_x[LW-1:0] : '0;
    assign add_drop = !lvl_ok || (count_reg[add_lvl] == CW'(QUEUE_DEPTH));
    assign tail_sum = (CW + 1)'(head_reg[add_lvl]) + (CW + 1)'(count_reg[add_lvl]);
    assign tail_pos = (tail_sum >= (CW + 1)'(QUEUE_DEPTH))
                    ? HW'(tail_sum - (CW + 1)'(QUEUE_DEPTH))
                    : HW'(tail_sum);

    assign ram_we    = exec && (op_reg == mlq_pkg::OP_ADD) && !add_drop;
    assign ram_re    = exec && (op_reg == mlq_pkg::OP_GET) && any_ok;
    assign ram_waddr = AW'(add_lvl) * AW'(QUEUE_DEPTH) + AW'(tail_pos);
    assign ram_raddr = AW'(srv_lvl) * AW'(QUEUE_DEPTH) + AW'(head_reg[srv_lvl]);

    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        used_next    = used_reg;
        cur_next     = cur_reg;
        granted_next = 1'b0;
        gprio_next   = '0;
        dropped_next = 1'b0;
        if (exec)
        begin
            if (op_reg == mlq_pkg::OP_ADD)
            begin
                dropped_next = add_drop;
                if (!add_drop)
                begin
                    count_next[add_lvl] = count_reg[add_lvl] + 1'b1;
                end
            end
            else if (any_ok)
            begin
                for (int p = 0; p < NUM_PRIO; p++)
                begin
                    if (clr_vec[p])
                    begin
                        used_next[p] = '0;
                    end
                end
                used_next[srv_lvl]  = used_reg[srv_lvl] + 1'b1;
                count_next[srv_lvl] = count_reg[srv_lvl] - 1'b1;
                head_next[srv_lvl]  = (head_reg[srv_lvl] == HW'(QUEUE_DEPTH - 1))
                                    ? '0 : head_reg[srv_lvl] + 1'b1;
                cur_next     = srv_lvl;
                granted_next = 1'b1;
                gprio_next   = (mlq_pkg::PRIO_W)'(srv_lvl);
            end
            else
            begin
                for (int p = 0; p < NUM_PRIO; p++)
                begin
                    used_next[p] = '0;
                end
                if (any_ne)
                begin
                    cur_next = wrap_lvl;
                end
            end
        end
    end

    always_comb
    begin
        empty_next = 1'b1;
        for (int p = 0; p < NUM_PRIO; p++)
        begin
            if (count_next[p] != '0)
            begin
                empty_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PRIO; p++)
            begin
                head_reg[p]  <= '0;
                count_reg[p] <= '0;
                used_reg[p]  <= '0;
            end
            cur_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            cur_reg   <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            granted_reg <= granted_next;
            gprio_reg   <= gprio_next;
            dropped_reg <= dropped_next;
            empty_reg   <= empty_next;
        end
    end

    mlq_ram #(
        .WIDTH (mlq_pkg::ID_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (id_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign done           = (state_reg == S_RESP);
    assign granted        = granted_reg;
    assign grant_id       = granted_reg ? ram_rdata : '0;
    assign grant_priority = gprio_reg;
    assign dropped        = dropped_reg;
    assign all_empty      = empty_reg;

`ifndef NO_ASSERTIONS
    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("transfer did not start execution");

    a_busy_done : assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("result not delivered one cycle after execution");

    a_grant_drop : assert property (@(posedge clk) disable iff (!rst_n)
        done && dropped |-> !granted && (grant_id == '0))
        else $error("dropped add reported a grant");

    a_grant_level : assert property (@(posedge clk) disable iff (!rst_n)
        exec && granted_next |-> ne_vec[srv_lvl])
        else $error("grant from an empty level");
`endif

endmodule

FILE: tb/sv/mlq_slot_budget_scheduler_checker.sv
`timescale 1ns / 1ps

module mlq_slot_budget_scheduler_checker #(
    parameter int NUM_PRIO    = mlq_pkg::NUM_PRIO_DEF,
    parameter int QUEUE_DEPTH = mlq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       op,
    input  logic [mlq_pkg::ID_W-1:0]   proc_id,
    input  logic [mlq_pkg::PRIO_W-1:0] priority_req,
    input  logic                       done,
    input  logic                       granted,
    input  logic [mlq_pkg::ID_W-1:0]   grant_id,
    input  logic [mlq_pkg::PRIO_W-1:0] grant_priority,
    input  logic                       dropped,
    input  logic                       all_empty,
    output int                         fail_count,
    output int                         outstanding,
    output int                         grants_seen,
    output int                         drops_seen
);

    typedef struct packed {
        logic                       granted;
        logic [mlq_pkg::ID_W-1:0]   grant_id;
        logic [mlq_pkg::PRIO_W-1:0] grant_priority;
        logic                       dropped;
        logic                       all_empty;
    } sched_result_t;

    logic [mlq_pkg::ID_W-1:0] ready_ids [NUM_PRIO][QUEUE_DEPTH];
    int              ready_head [NUM_PRIO];
    int              ready_count [NUM_PRIO];
    int              slots_used [NUM_PRIO];
    int              scan_level;

    sched_result_t   pending_results [$];
    sched_result_t   got;
    sched_result_t   want;
    int              fails;
    int              grants;
    int              drops;

    task automatic clear_ready_queues();
        for (int p = 0; p < NUM_PRIO; p++)
        begin
            ready_head[p]  = 0;
            ready_count[p] = 0;
            slots_used[p]  = 0;
        end
        scan_level = 0;
    endtask

    task automatic schedule_command(
        input  logic                       cmd,
        input  logic [mlq_pkg::ID_W-1:0]   pid,
        input  logic [mlq_pkg::PRIO_W-1:0] lvl,
        output sched_result_t              r
    );
        int p;
        bit hit;
        r   = '0;
        hit = 1'b0;
        if (cmd == mlq_pkg::OP_ADD)
        begin
            if (int'(lvl) >= NUM_PRIO || ready_count[lvl] >= QUEUE_DEPTH)
                r.dropped = 1'b1;
            else
            begin
                ready_ids[lvl][(ready_head[lvl] + ready_count[lvl]) % QUEUE_DEPTH] = pid;
                ready_count[lvl]++;
            end
        end
        else
        begin
            p = scan_level % NUM_PRIO;
            for (int i = 0; i < NUM_PRIO && !hit; i++)
            begin
                if (ready_count[p] != 0)
                begin
                    if (slots_used[p] < NUM_PRIO - p)
                    begin
                        r.grant_id       = ready_ids[p][ready_head[p]];
                        r.grant_priority = (mlq_pkg::PRIO_W)'(p);
                        r.granted        = 1'b1;
                        ready_head[p]    = (ready_head[p] + 1) % QUEUE_DEPTH;
                        ready_count[p]--;
                        slots_used[p]++;
                        scan_level       = p;
                        hit              = 1'b1;
                    end
                    else
                    begin
                        // budget spent: reset it and move past this level
                        slots_used[p] = 0;
                        scan_level    = (p + 1) % NUM_PRIO;
                    end
                end
                if (!hit)
                    p = (p + 1) % NUM_PRIO;
            end
            if (!hit)
                for (int q = 0; q < NUM_PRIO; q++)
                    slots_used[q] = 0;
        end
        r.all_empty = 1'b1;
        for (int q = 0; q < NUM_PRIO; q++)
            if (ready_count[q] != 0)
                r.all_empty = 1'b0;
    endtask

    task automatic check_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", field, exp_val, act_val);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_ready_queues();
            pending_results.delete();
            fails       = 0;
            grants      = 0;
            drops       = 0;
            fail_count  <= 0;
            outstanding <= 0;
            grants_seen <= 0;
            drops_seen  <= 0;
        end
        else
        begin
            if (done)
            begin
                got = '{granted, grant_id, grant_priority, dropped, all_empty};
                grants += int'(got.granted);
                drops  += int'(got.dropped);
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    fails++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("granted", int'(want.granted), int'(got.granted));
                    check_field("grant_id", int'(want.grant_id), int'(got.grant_id));
                    check_field("grant_priority", int'(want.grant_priority),
                                int'(got.grant_priority));
                    check_field("dropped", int'(want.dropped), int'(got.dropped));
                    check_field("all_empty", int'(want.all_empty), int'(got.all_empty));
                end
            end
            if (start && !busy)
            begin
                schedule_command(op, proc_id, priority_req, want);
                pending_results.push_back(want);
            end
            fail_count  <= fails;
            outstanding <= pending_results.size();
            grants_seen <= grants;
            drops_seen  <= drops;
        end
    end

endmodule

FILE: tb/sv/mlq_slot_budget_scheduler_tb.sv
`timescale 1ns / 1ps

module mlq_slot_budget_scheduler_tb;

    localparam int RANDOM_ITEMS = 1600;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       start        = 1'b0;
    logic                       op           = mlq_pkg::OP_ADD;
    logic [mlq_pkg::ID_W-1:0]   proc_id      = '0;
    logic [mlq_pkg::PRIO_W-1:0] priority_req = '0;
    logic                       busy;
    logic                       done;
    logic                       granted;
    logic [mlq_pkg::ID_W-1:0]   grant_id;
    logic [mlq_pkg::PRIO_W-1:0] grant_priority;
    logic                       dropped;
    logic                       all_empty;

    int fail_count;
    int outstanding;
    int grants_seen;
    int drops_seen;
    int commands_sent = 0;

    always #4 clk = ~clk;

    mlq_slot_budget_scheduler i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .proc_id        (proc_id),
        .priority_req   (priority_req),
        .done           (done),
        .granted        (granted),
        .grant_id       (grant_id),
        .grant_priority (grant_priority),
        .dropped        (dropped),
        .all_empty      (all_empty)
    );

    mlq_slot_budget_scheduler_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .proc_id        (proc_id),
        .priority_req   (priority_req),
        .done           (done),
        .granted        (granted),
        .grant_id       (grant_id),
        .grant_priority (grant_priority),
        .dropped        (dropped),
        .all_empty      (all_empty),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .grants_seen    (grants_seen),
        .drops_seen     (drops_seen)
    );

    // holds start high until the command transfers; start is left high
    task automatic issue(input logic cmd, input logic [mlq_pkg::ID_W-1:0] pid,
                         input logic [mlq_pkg::PRIO_W-1:0] lvl);
        start        <= 1'b1;
        op           <= cmd;
        proc_id      <= pid;
        priority_req <= lvl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        commands_sent++;
    endtask

    task automatic idle_gap();
        start <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [mlq_pkg::ID_W-1:0] edge_ids [8];
        int mode;
        int len;
        int flood_lvl;
        int chunk;
        bit gappy;
        bit is_add;

        edge_ids = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // request on empty queues, one process per level, overfill
        // level 7 so its one-slot budget runs out during the scan
        issue(mlq_pkg::OP_GET, 8'hFF, 3'd7);
        for (int p = 0; p < 8; p++)
            issue(mlq_pkg::OP_ADD, edge_ids[p], (mlq_pkg::PRIO_W)'(p));
        issue(mlq_pkg::OP_ADD, 8'h0F, 3'd7);
        issue(mlq_pkg::OP_ADD, 8'hF0, 3'd7);
        for (int k = 0; k < 12; k++)
            issue(mlq_pkg::OP_GET, (mlq_pkg::ID_W)'($urandom),
                  (mlq_pkg::PRIO_W)'($urandom));
        wait_drained();

        chunk = 0;
        while (commands_sent < RANDOM_ITEMS)
        begin
            mode      = $urandom_range(0, 3);
            len       = (mode == 3) ? $urandom_range(10, 24) : $urandom_range(8, 48);
            flood_lvl = $urandom_range(0, 7);
            gappy     = (commands_sent < RANDOM_ITEMS - 300) && ($urandom_range(0, 2) != 0);
            for (int k = 0; k < len; k++)
            begin
                case (mode)
                    0:       is_add = ($urandom_range(0, 99) < 85);
                    1:       is_add = ($urandom_range(0, 99) < 15);
                    2:       is_add = 1'($urandom_range(0, 1));
                    default: is_add = 1'b1;
                endcase
                issue(is_add ? mlq_pkg::OP_ADD : mlq_pkg::OP_GET,
                      (mlq_pkg::ID_W)'($urandom),
                      (mode == 3) ? (mlq_pkg::PRIO_W)'(flood_lvl)
                                  : (mlq_pkg::PRIO_W)'($urandom_range(0, 7)));
                if (gappy && $urandom_range(0, 3) == 0)
                    idle_gap();
            end
            chunk++;
            if (chunk % 9 == 4)
                wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Sent %0d commands through add bursts, request bursts and level floods;",
                 commands_sent);
        $display("saw %0d grants and %0d adds refused on full levels.", grants_seen, drops_seen);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mlq_pkg.sv
rtl/core/mlq_ram.sv
rtl/core/mlq_slot_budget_scheduler.sv
tb/sv/mlq_slot_budget_scheduler_checker.sv
tb/sv/mlq_slot_budget_scheduler_tb.sv
